// File: hw/rtl/assert_macros.svh
// Assertion helpers; compiled out under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// prop must hold at every clock edge outside reset
`define VTSE_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// prop must never hold outside reset
`define VTSE_NEVER(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(prop)) else $error(msg);

`else

`define VTSE_ASSERT(lbl, clk, rst_n, prop, msg)
`define VTSE_NEVER(lbl, clk, rst_n, prop, msg)

`endif

`endif

// File: hw/rtl/vtse_pkg.sv
`timescale 1ns / 1ps

package vtse_pkg;

	localparam int CAPACITY = 8;
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);

	// request codes
	localparam logic [1:0] OP_APPEND  = 2'd0;
	localparam logic [1:0] OP_REPLACE = 2'd1;
	localparam logic [1:0] OP_DELETE  = 2'd2;

	// result status codes
	localparam logic [1:0] ST_DONE      = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_RESULT
	} state_t;

endpackage

// File: hw/rtl/value_table_search_edit_core.sv
`timescale 1ns / 1ps
// Sequencing, accept to result word: append, empty-table miss and code 3 go straight
//   to the result state; replace and delete first scan from entry 0 (one entry per
//   cycle), and a delete hit then moves each later entry down one slot.
// Throughput: one request at a time; the next word is taken only once the result
//   word is loaded into the output register and the block is back in idle (single memory read port).
// Reset: arst_n clears control and fill count; entry memory has no reset.
`include "assert_macros.svh"

module value_table_search_edit_core
	import vtse_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// request channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic        [1:0]  operation,
	input  logic signed [31:0] key,
	input  logic signed [31:0] new_value,
	// result channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic        [1:0]  status,
	output logic        [2:0]  match_index,
	output logic        [3:0]  fill_count
);

	localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
	localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(CAPACITY);

	// entry store: one synchronous read port, one write port
	logic [31:0] mem [CAPACITY];
	logic [31:0] rd_data_q;

	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [31:0]      wr_data;

	// control state
	state_t           state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [IDX_W-1:0] ptr_q, ptr_d;     // address of the entry now in rd_data_q
	logic [1:0]       res_status_q, res_status_d;
	logic [IDX_W-1:0] res_idx_q, res_idx_d;

	// captured request word
	logic [1:0]  op_q;
	logic [31:0] key_q;
	logic [31:0] val_q;

	// output word register
	logic       out_valid_q;
	logic [1:0] status_q;
	logic [2:0] match_index_q;
	logic [3:0] fill_count_q;
	logic       load_out;

	logic             accept;
	logic [IDX_W-1:0] ptr_next;
	logic             more;
	logic             hit;

	assign accept   = in_valid && in_ready;
	assign ptr_next = ptr_q + IDX_W'(1);
	// another live entry after the current one
	assign more     = (CNT_W'(ptr_q) + CNT_ONE) < count_q;
	assign hit      = (rd_data_q == key_q);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= operation;
			key_q <= key;
			val_q <= new_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			ptr_q        <= '0;
			res_status_q <= ST_DONE;
			res_idx_q    <= '0;
		end else begin
			state_q      <= state_d;
			count_q      <= count_d;
			ptr_q        <= ptr_d;
			res_status_q <= res_status_d;
			res_idx_q    <= res_idx_d;
		end
	end

	// Sequencer: scan reads one entry per cycle and compares the registered
	// read word; delete then moves each later entry down one slot, reading
	// ptr+1 while writing ptr-1, so the two accesses never meet.
	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		ptr_d        = ptr_q;
		res_status_d = res_status_q;
		res_idx_d    = res_idx_q;
		rd_en        = 1'b0;
		rd_addr      = ptr_next;
		wr_en        = 1'b0;
		wr_addr      = ptr_q;
		wr_data      = val_q;
		in_ready     = 1'b0;
		load_out     = 1'b0;

		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					res_idx_d = '0;
					case (operation)
						OP_APPEND: begin
							if (count_q >= CNT_CAP) begin
								res_status_d = ST_FULL;
							end else begin
								wr_en        = 1'b1;
								wr_addr      = IDX_W'(count_q);
								wr_data      = new_value;
								res_status_d = ST_DONE;
								res_idx_d    = IDX_W'(count_q);
								count_d      = count_q + CNT_ONE;
							end
							state_d = S_RESULT;
						end
						OP_REPLACE, OP_DELETE: begin
							if (count_q == '0) begin
								res_status_d = ST_NOT_FOUND;
								state_d      = S_RESULT;
							end else begin
								rd_en   = 1'b1;
								rd_addr = '0;
								ptr_d   = '0;
								state_d = S_SCAN;
							end
						end
						default: begin
							res_status_d = ST_NOT_FOUND;
							state_d      = S_RESULT;
						end
					endcase
				end
			end
			S_SCAN: begin
				if (hit) begin
					res_status_d = ST_DONE;
					res_idx_d    = ptr_q;
					if (op_q == OP_REPLACE) begin
						wr_en   = 1'b1;
						wr_addr = ptr_q;
						wr_data = val_q;
						state_d = S_RESULT;
					end else if (more) begin
						rd_en   = 1'b1;
						ptr_d   = ptr_next;
						state_d = S_SHIFT;
					end else begin
						// matched the last entry: nothing to move
						count_d = count_q - CNT_ONE;
						state_d = S_RESULT;
					end
				end else if (more) begin
					rd_en = 1'b1;
					ptr_d = ptr_next;
				end else begin
					res_status_d = ST_NOT_FOUND;
					res_idx_d    = '0;
					state_d      = S_RESULT;
				end
			end
			S_SHIFT: begin
				wr_en   = 1'b1;
				wr_addr = ptr_q - IDX_W'(1);
				wr_data = rd_data_q;
				if (more) begin
					rd_en = 1'b1;
					ptr_d = ptr_next;
				end else begin
					count_d = count_q - CNT_ONE;
					state_d = S_RESULT;
				end
			end
			S_RESULT: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			status_q      <= res_status_q;
			match_index_q <= 3'(res_idx_q);
			fill_count_q  <= 4'(count_q);
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign match_index = match_index_q;
	assign fill_count  = fill_count_q;

	// fill count stays within the table
	`VTSE_NEVER(a_count_range, clk, arst_n, count_q > CNT_CAP, "fill count above capacity")
	// shift pointer always sits on a live entry past the deleted one
	`VTSE_NEVER(a_shift_lo, clk, arst_n, (state_q == S_SHIFT) && (ptr_q == '0), "shift at entry 0")
	`VTSE_NEVER(a_shift_hi, clk, arst_n, (state_q == S_SHIFT) && (CNT_W'(ptr_q) >= count_q), "shift past count")
	// count moves by at most one per request
	`VTSE_NEVER(a_count_up, clk, arst_n, count_q > $past(count_q) + CNT_ONE, "fill count jumped up")
	`VTSE_NEVER(a_count_dn, clk, arst_n, count_q + CNT_ONE < $past(count_q), "fill count jumped down")

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
	import vtse_pkg::*;

	// code 3 is not a request; the block answers it as a miss
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

	// idle edges with no word moving on either side before giving up
	localparam int QUIET_LIMIT = 4000;
	// settle time after the last result word: worst scan plus shift, with margin
	localparam int TAIL_CYCLES = 32;

	typedef struct packed {
		logic [1:0] status;
		logic [2:0] idx;
		logic [3:0] count;
	} result_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic               in_valid = 1'b0;
	logic               in_ready;
	logic        [1:0]  operation = OP_APPEND;
	logic signed [31:0] key = '0;
	logic signed [31:0] new_value = '0;

	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  status;
	logic [2:0]  match_index;
	logic [3:0]  fill_count;

	// shadow copy of the table, updated as each request word is taken
	logic signed [31:0] shadow_vals [CAPACITY];
	int shadow_count = 0;

	// result words still owed by the block, oldest first
	result_word_t pending_results[$];

	int mismatch_count = 0;
	int quiet_cycles = 0;

	// idle rates in percent for the two sides
	int send_gap_pct = 0;
	int recv_stall_pct = 0;

	value_table_search_edit_core uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.operation  (operation),
		.key        (key),
		.new_value  (new_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.match_index(match_index),
		.fill_count (fill_count)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Table behavior: first match wins (lowest index), delete closes the hole,
	// misses and code 3 leave the table alone and report not-found.
	function automatic result_word_t apply_request(input logic [1:0] op,
			input logic signed [31:0] k, input logic signed [31:0] v);
		result_word_t r;
		int hit;
		int i;
		r.status = ST_NOT_FOUND;
		r.idx = '0;
		hit = -1;
		for (i = shadow_count - 1; i >= 0; i--)
			if (shadow_vals[i] == k)
				hit = i;
		case (op)
			OP_APPEND: begin
				if (shadow_count >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					shadow_vals[shadow_count] = v;
					r.idx = shadow_count[2:0];
					shadow_count++;
					r.status = ST_DONE;
				end
			end
			OP_REPLACE: begin
				if (hit >= 0) begin
					shadow_vals[hit] = v;
					r.idx = hit[2:0];
					r.status = ST_DONE;
				end
			end
			OP_DELETE: begin
				if (hit >= 0) begin
					for (i = hit; i < shadow_count - 1; i++)
						shadow_vals[i] = shadow_vals[i + 1];
					shadow_count--;
					r.idx = hit[2:0];
					r.status = ST_DONE;
				end
			end
			default: ;
		endcase
		r.count = shadow_count[3:0];
		return r;
	endfunction

	// Present one request word and hold it until taken. Valid stays high on
	// return; the caller's next move in the same step decides its fate.
	task automatic send_word(input logic [1:0] op, input logic signed [31:0] k,
			input logic signed [31:0] v);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		key <= k;
		new_value <= v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_results.push_back(apply_request(op, k, v));
	endtask

	// Sender backs off until every owed result word is back.
	task automatic hold_until_drained();
		if (pending_results.size() != 0) begin
			in_valid <= 1'b0;
			while (pending_results.size() != 0)
				@(posedge clk);
		end
	endtask

	task automatic test_empty_table();
		send_word(OP_REPLACE, '0, $urandom);
		send_word(OP_DELETE, VAL_MIN, $urandom);
		send_word(OP_UNUSED, $urandom, $urandom);
	endtask

	// extremes and alternating patterns, then one past capacity
	task automatic test_fill_to_full();
		send_word(OP_APPEND, $urandom, VAL_MIN);
		send_word(OP_APPEND, $urandom, VAL_MAX);
		send_word(OP_APPEND, $urandom, 32'sd0);
		send_word(OP_APPEND, $urandom, -32'sd1);
		send_word(OP_APPEND, $urandom, VAL_MAX);
		send_word(OP_APPEND, $urandom, 32'sd1);
		send_word(OP_APPEND, $urandom, 32'sh5555_5555);
		send_word(OP_APPEND, $urandom, 32'shAAAA_AAAA);
		send_word(OP_APPEND, $urandom, 32'sd7);
		send_word(OP_UNUSED, VAL_MAX, $urandom);
	endtask

	// duplicates present: only the lowest index may be touched
	task automatic test_first_match();
		send_word(OP_REPLACE, VAL_MAX, VAL_MIN);
		send_word(OP_DELETE, VAL_MIN, $urandom);
		send_word(OP_REPLACE, 32'sd12345, $urandom);
	endtask

	// last entry, first entry (full shift), miss, then a fresh duplicate
	task automatic test_delete_shift();
		send_word(OP_DELETE, 32'shAAAA_AAAA, $urandom);
		send_word(OP_DELETE, VAL_MIN, $urandom);
		send_word(OP_DELETE, 32'sd99, $urandom);
		send_word(OP_APPEND, $urandom, 32'sd0);
		send_word(OP_DELETE, 32'sd0, $urandom);
	endtask

	// Mostly keys that are in the table so replace/delete actually land;
	// small values give duplicates, full-range values toggle every bit.
	task automatic test_random_traffic(input int n);
		int pick;
		int append_cut;
		logic [1:0] op;
		logic signed [31:0] k;
		logic signed [31:0] v;
		repeat (n) begin
			append_cut = (shadow_count <= 2) ? 55 : ((shadow_count >= CAPACITY - 1) ? 20 : 38);
			pick = $urandom_range(99);
			if (pick < append_cut)
				op = OP_APPEND;
			else if (pick < append_cut + 27)
				op = OP_REPLACE;
			else if (pick < 95)
				op = OP_DELETE;
			else
				op = OP_UNUSED;

			pick = $urandom_range(99);
			if (shadow_count > 0 && pick < 65)
				k = shadow_vals[$urandom_range(shadow_count - 1)];
			else if (pick < 80)
				k = int'($urandom_range(6)) - 3;
			else
				k = $urandom;

			v = ($urandom_range(99) < 40) ? int'($urandom_range(6)) - 3 : $urandom;
			send_word(op, k, v);
			if ($urandom_range(99) == 0)
				hold_until_drained();
		end
	endtask

	task automatic note_mismatch(input string what, input int want, input int got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t mismatch %s: expected %0d, got %0d", $realtime, what, want, got);
	endtask

	// Result side: random stall on ready, check every word that moves.
	result_word_t oldest;
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				note_mismatch("unexpected result word (count)", 0, 1);
			end else begin
				oldest = pending_results.pop_front();
				if (status !== oldest.status)
					note_mismatch("status", oldest.status, status);
				if (match_index !== oldest.idx)
					note_mismatch("match_index", oldest.idx, match_index);
				if (fill_count !== oldest.count)
					note_mismatch("fill_count", oldest.count, fill_count);
			end
		end
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Watchdog: any word moving on either channel resets the count.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles, %0d words owed",
				QUIET_LIMIT, pending_results.size());
			$display("tb: failure");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sender mostly busy, receiver stalls about half the time
		send_gap_pct = 9;
		recv_stall_pct = 47;
		test_empty_table();
		test_fill_to_full();
		test_first_match();
		test_delete_shift();
		hold_until_drained();
		test_random_traffic(176);

		// sender sparse, receiver mostly ready
		send_gap_pct = 47;
		recv_stall_pct = 9;
		test_random_traffic(176);

		// back to back
		send_gap_pct = 0;
		recv_stall_pct = 0;
		test_random_traffic(176);

		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/vtse_pkg.sv
hw/rtl/value_table_search_edit_core.sv
tb/tb.sv
